[hdl/i2cbm_pkg.sv]
// types, codes and reset values shared by the i2c byte-level master
// no dependencies
package i2cbm_pkg;

  // command codes of the op field
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_LONG_PHASE  = 2'd0;
  localparam logic [1:0] CFG_BIT_PHASE   = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam logic [7:0] LONG_PHASE_RESET  = 8'd4;
  localparam logic [7:0] BIT_PHASE_RESET   = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd50;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_WR_TAIL,
    PH_AK_LOW,
    PH_AK_HIGH,
    PH_AK_POLL,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_RA_LOW,
    PH_RA_HIGH,
    PH_FIN
  } phase_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } out_t;

  typedef struct packed {
    logic [7:0] long_phase_ticks;
    logic [7:0] bit_phase_ticks;
    logic [7:0] ack_timeout_limit;
  } cfg_t;

  // sequencer state
  typedef struct packed {
    phase_e     ph;
    logic [2:0] cmd;
    logic [3:0] bc;
    logic [7:0] tc;
    logic [7:0] rc;
    logic [7:0] sr;
    logic [7:0] rb;
    logic       ack;
    logic       err;
    logic       scl;
    logic       sda;
  } st_t;

  localparam st_t ST_RESET = '{
    ph: PH_IDLE, cmd: OP_NONE, bc: 4'd0, tc: 8'd0, rc: 8'd0, sr: 8'd0,
    rb: 8'd0, ack: 1'b0, err: 1'b0, scl: 1'b1, sda: 1'b1
  };

endpackage

[hdl/i2c_byte_level_master.sv]
// top level of the i2c byte-level master: configuration registers and channel glue
// depends on i2cbm_pkg, i2cbm_core and i2cbm_out_reg
//
// usage: every input transaction on in_* is one bus tick carrying an optional
// command (start, stop, write byte, read byte) and the sampled SDA level.
// each tick produces exactly one result transaction on out_* with the SCL
// level, SDA drive, busy/done flags, last received byte and ack error flag.
// the sequencer step for a tick is computed in a single pass; the result shows on out_*
// the cycle after the tick is taken, and one tick is taken every cycle while
// results drain. the output register sets that rate.
// if the receiver stalls out_ready_i, the pending result holds and in_ready_o
// drops until it is taken. configuration writes on cfg_* are always taken
// (cfg_ready_o is high); index 0 long phase, 1 bit phase, 2 ack timeout,
// other indexes are ignored. write configuration only while no command runs.
// reset returns the sequencer to idle with SCL and SDA released and loads
// the configuration defaults 4, 1 and 50.
module i2c_byte_level_master (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  i2cbm_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output i2cbm_pkg::out_t  out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i
);
  import i2cbm_pkg::*;

  cfg_t cfg_q, cfg_d;
  out_t res;
  logic step;
  logic ready;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LONG_PHASE:  cfg_d.long_phase_ticks  = cfg_data_i;
        CFG_BIT_PHASE:   cfg_d.bit_phase_ticks   = cfg_data_i;
        CFG_ACK_TIMEOUT: cfg_d.ack_timeout_limit = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{long_phase_ticks: LONG_PHASE_RESET, bit_phase_ticks: BIT_PHASE_RESET,
                 ack_timeout_limit: ACK_TIMEOUT_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = ready;
  assign step       = in_valid_i && ready;

  i2cbm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  i2cbm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/i2cbm_core.sv]
// bus sequencer: state registers and the single-pass step for one tick
// depends on i2cbm_pkg
module i2cbm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cbm_pkg::in_t    item_i,
  input  i2cbm_pkg::cfg_t   cfg_i,
  output i2cbm_pkg::out_t   res_o
);
  import i2cbm_pkg::*;

  st_t st_q, st_d;

  function automatic logic [7:0] phase_len(phase_e p, cfg_t c);
    logic [7:0] n;
    n = (p == PH_ST_A || p == PH_ST_B || p == PH_SP_A || p == PH_SP_B) ?
        c.long_phase_ticks : c.bit_phase_ticks;
    return (n == 8'd0) ? 8'd1 : n;
  endfunction

  function automatic st_t enter_phase(st_t s, phase_e p, phase_e from);
    st_t r;
    r = s;
    r.ph = p;
    r.tc = 8'd0;
    case (p)
      PH_ST_A: begin r.scl = 1'b1; r.sda = 1'b1; end
      PH_ST_B: begin r.scl = 1'b1; r.sda = 1'b0; end
      PH_SP_A: begin r.scl = 1'b0; r.sda = 1'b0; end
      PH_SP_B: begin r.scl = 1'b1; r.sda = 1'b1; end
      PH_WR_LOW: begin r.scl = 1'b0; r.sda = s.sr[7]; end
      PH_AK_LOW: begin r.scl = 1'b0; r.sda = 1'b1; r.rc = 8'd0; end
      PH_RD_LOW: begin r.scl = 1'b0; r.sda = 1'b1; end
      PH_RA_LOW: begin r.scl = 1'b0; r.sda = ~s.ack; end
      PH_WR_TAIL: r.scl = 1'b0;
      PH_WR_HIGH, PH_AK_HIGH, PH_AK_POLL, PH_RD_HIGH, PH_RA_HIGH: r.scl = 1'b1;
      PH_FIN: begin
        if (from != PH_SP_B) r.scl = 1'b0;
        if (s.cmd == OP_READ) r.rb = s.sr;
      end
      default: ;
    endcase
    return r;
  endfunction

  always_comb begin : step_comb
    st_t    s;
    logic   jump;
    phase_e nxt;
    phase_e cur;
    logic   busy;
    logic   done;
    logic   scl_out;
    logic   sda_out;
    s    = st_q;
    jump = 1'b0;
    nxt  = PH_IDLE;
    busy = 1'b0;
    done = 1'b0;

    // commands are taken only while idle
    if (s.ph == PH_IDLE && (item_i.op == OP_START || item_i.op == OP_STOP ||
                            item_i.op == OP_WRITE || item_i.op == OP_READ)) begin
      s.cmd = item_i.op;
      s.bc  = 4'd0;
      if (item_i.op == OP_WRITE) begin
        s.sr  = item_i.tx_byte;
        s.err = 1'b0;
      end
      if (item_i.op == OP_READ) begin
        s.sr  = 8'd0;
        s.ack = item_i.send_ack;
      end
      case (item_i.op)
        OP_START: s = enter_phase(s, PH_ST_A, PH_IDLE);
        OP_STOP:  s = enter_phase(s, PH_SP_A, PH_IDLE);
        OP_WRITE: s = enter_phase(s, PH_WR_LOW, PH_IDLE);
        default:  s = enter_phase(s, PH_RD_LOW, PH_IDLE);
      endcase
    end

    // lines shown this tick are those set on entry
    scl_out = s.scl;
    sda_out = s.sda;
    cur     = s.ph;

    if (cur == PH_FIN) begin
      done = 1'b1;
      s.ph = PH_IDLE;
    end else if (cur != PH_IDLE) begin
      busy = 1'b1;
      if (cur == PH_RD_HIGH && s.tc == 8'd0) s.sr = {s.sr[6:0], item_i.sda_sample};
      if (cur == PH_AK_POLL && s.tc == 8'd0) begin
        if (!item_i.sda_sample) begin
          jump = 1'b1;
          nxt  = PH_FIN;
        end else begin
          if (s.rc != 8'hFF) s.rc = s.rc + 8'd1;
          if (s.rc > cfg_i.ack_timeout_limit) begin
            s.err = 1'b1;
            jump  = 1'b1;
            nxt   = PH_SP_A;
          end
        end
      end
      s.tc = s.tc + 8'd1;
      if (jump) begin
        s = enter_phase(s, nxt, cur);
      end else if (s.tc >= phase_len(cur, cfg_i)) begin
        case (cur)
          PH_ST_A: s = enter_phase(s, PH_ST_B, cur);
          PH_SP_A: s = enter_phase(s, PH_SP_B, cur);
          PH_ST_B, PH_SP_B, PH_RA_HIGH: s = enter_phase(s, PH_FIN, cur);
          PH_WR_LOW: s = enter_phase(s, PH_WR_HIGH, cur);
          PH_WR_HIGH: s = enter_phase(s, PH_WR_TAIL, cur);
          PH_WR_TAIL: begin
            s.sr = {s.sr[6:0], 1'b0};
            s.bc = s.bc + 4'd1;
            s = enter_phase(s, (s.bc >= BITS_PER_BYTE) ? PH_AK_LOW : PH_WR_LOW, cur);
          end
          PH_AK_LOW: s = enter_phase(s, PH_AK_HIGH, cur);
          PH_AK_HIGH, PH_AK_POLL: s = enter_phase(s, PH_AK_POLL, cur);
          PH_RD_LOW: s = enter_phase(s, PH_RD_HIGH, cur);
          PH_RD_HIGH: begin
            s.bc = s.bc + 4'd1;
            s = enter_phase(s, (s.bc >= BITS_PER_BYTE) ? PH_RA_LOW : PH_RD_LOW, cur);
          end
          PH_RA_LOW: s = enter_phase(s, PH_RA_HIGH, cur);
          default: s.ph = PH_IDLE;
        endcase
      end
    end

    st_d              = s;
    res_o.scl_level   = scl_out;
    res_o.sda_release = sda_out;
    res_o.busy_res    = busy;
    res_o.done_res    = done;
    res_o.rx_byte     = s.rb;
    res_o.ack_error   = s.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  a_fin_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && st_q.ph == PH_FIN |=> st_q.ph == PH_IDLE)
    else $error("finish tick not followed by idle");

  a_hold_without_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(st_q))
    else $error("sequencer state moved without a tick");

  a_ack_after_eight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && st_q.ph == PH_WR_TAIL && st_d.ph == PH_AK_LOW |-> st_d.bc == BITS_PER_BYTE)
    else $error("acknowledge wait entered before eight bits");

  a_error_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !st_q.err && st_d.err |-> st_d.ph == PH_SP_A)
    else $error("ack timeout did not start a stop condition");

endmodule

[hdl/i2cbm_out_reg.sv]
// result register that decouples the result side from the tick side
// depends on i2cbm_pkg
module i2cbm_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  i2cbm_pkg::out_t  res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output i2cbm_pkg::out_t  out_data_o
);
  import i2cbm_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  // a new result may enter when the register is empty or drains this cycle
  assign ready_o = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
